/* sv/quoted_argument_tokenizer_macros.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clk edge outside reset.
`define QAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/qat_pkg.sv */
`default_nettype none

package qat_pkg;

	localparam int unsigned MAX_ARG_SLOTS = 16;
	localparam int unsigned STORE_BYTES   = 4096;

	localparam logic [12:0] RAW_MAX   = 13'h1FFF;
	localparam logic [12:0] STORE_CAP = 13'(STORE_BYTES);

	localparam int unsigned MAX_RES    = 3;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	localparam logic REG_MAX_ARGS    = 1'b0;
	localparam logic REG_STORE_LIMIT = 1'b1;

	localparam logic [4:0]  MAX_ARGS_RST    = 5'd16;
	localparam logic [12:0] STORE_LIMIT_RST = 13'd1024;

	typedef enum logic [3:0] {
		MODE_BETWEEN  = 4'b0001,
		MODE_UNQUOTED = 4'b0010,
		MODE_QUOTED   = 4'b0100,
		MODE_DISCARD  = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic        held;
		logic [4:0]  arg_total;
		logic [12:0] bytes_used;
		logic [12:0] raw_len;
		logic [12:0] stored_len;
		logic        failed;
	} tok_state_t;

	localparam tok_state_t STATE_RESET = '{
		mode:       MODE_BETWEEN,
		held:       1'b0,
		arg_total:  5'd0,
		bytes_used: 13'd0,
		raw_len:    13'd0,
		stored_len: 13'd0,
		failed:     1'b0
	};

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_byte;
		logic [3:0] arg_index;
		logic       arg_end;
		logic       arg_accepted;
		logic       string_done;
		logic       success;
		logic [4:0] arg_count;
		logic       last;
	} res_t;

	typedef struct packed {
		logic             room;
		logic             nonempty;
		logic [LVL_W-1:0] level;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* sv/qat_step.sv */
`default_nettype none

module qat_step (
	input  qat_pkg::tok_state_t                st,
	input  logic [4:0]                         max_args,
	input  logic [12:0]                        store_limit,
	input  logic [7:0]                         in_byte,
	output qat_pkg::tok_state_t                st_next,
	output qat_pkg::res_t [qat_pkg::MAX_RES-1:0] res,
	output logic [1:0]                         res_n
);
	import qat_pkg::*;

	logic        is_z, is_sp, is_q, is_bs;
	logic        start, ab, fl, en, dn;
	mode_t       nmode;
	logic        held0, held1, emit_bs, emit_c, ok, fail_a;
	logic [12:0] raw0, raw1, st0, stored1, limit;
	logic [14:0] need;
	logic [4:0]  total_end, tot_a;
	res_t        cand [4];
	logic [3:0]  cv;
	logic [1:0]  k;

	assign is_z  = (in_byte == CH_NUL);
	assign is_sp = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
	               (in_byte == CH_LF) || (in_byte == CH_CR);
	assign is_q  = (in_byte == CH_QUOTE);
	assign is_bs = (in_byte == CH_BSL);

	always_comb begin
		start = 1'b0;
		ab    = 1'b0;
		fl    = 1'b0;
		en    = 1'b0;
		dn    = 1'b0;
		nmode = st.mode;
		case (st.mode)
			MODE_BETWEEN: begin
				if (is_z) begin
					dn = 1'b1;
				end else if (!is_sp) begin
					start = 1'b1;
					if (is_q) begin
						nmode = MODE_QUOTED;
					end else begin
						nmode = MODE_UNQUOTED;
						ab    = 1'b1;
					end
				end
			end
			MODE_UNQUOTED: begin
				if (is_z) begin
					fl = 1'b1;
					en = 1'b1;
					dn = 1'b1;
				end else if (is_sp) begin
					fl = 1'b1;
					en = 1'b1;
				end else begin
					ab = 1'b1;
				end
			end
			MODE_QUOTED: begin
				if (is_z) begin
					fl = 1'b1;
					en = 1'b1;
					dn = 1'b1;
				end else if (is_q && !st.held) begin
					en = 1'b1;
				end else begin
					ab = 1'b1;
				end
			end
			MODE_DISCARD: begin
				dn = is_z;
			end
			default: begin
				nmode = MODE_BETWEEN;
			end
		endcase
	end

	// argument byte / flush datapath
	always_comb begin
		held0   = start ? 1'b0 : st.held;
		raw0    = start ? 13'd0 : st.raw_len;
		st0     = start ? 13'd0 : st.stored_len;
		emit_bs = 1'b0;
		emit_c  = 1'b0;
		held1   = held0;
		raw1    = raw0;
		if (ab) begin
			raw1 = (raw0 < RAW_MAX) ? raw0 + 13'd1 : raw0;
			if (is_q) begin
				emit_c = 1'b1;
				held1  = 1'b0;
			end else if (is_bs) begin
				emit_bs = held0;
				held1   = 1'b1;
			end else begin
				emit_bs = held0;
				emit_c  = 1'b1;
				held1   = 1'b0;
			end
		end else if (fl) begin
			emit_bs = held0;
			held1   = 1'b0;
		end
		stored1 = st0 + 13'(emit_bs) + 13'(emit_c);
	end

	// limit checks at argument end
	always_comb begin
		limit     = (store_limit < STORE_CAP) ? store_limit : STORE_CAP;
		need      = 15'(st.bytes_used) + 15'(raw1) + 15'd1;
		ok        = (st.arg_total < max_args) &&
		            (32'(st.arg_total) < MAX_ARG_SLOTS) &&
		            (need <= 15'(limit));
		total_end = ok ? st.arg_total + 5'd1 : st.arg_total;
		tot_a     = en ? total_end : st.arg_total;
		fail_a    = st.failed | (en & ~ok);
	end

	always_comb begin
		st_next            = st;
		st_next.mode       = nmode;
		st_next.held       = held1;
		st_next.raw_len    = raw1;
		st_next.stored_len = stored1;
		if (en) begin
			if (ok) begin
				st_next.arg_total  = total_end;
				st_next.bytes_used = st.bytes_used + stored1 + 13'd1;
				st_next.mode       = MODE_BETWEEN;
			end else begin
				st_next.failed = 1'b1;
				st_next.mode   = MODE_DISCARD;
			end
		end
		if (dn) begin
			st_next = STATE_RESET;
		end
	end

	// candidates in emission order: held backslash, char, arg end, string end
	always_comb begin
		cand[0]            = '0;
		cand[0].char_valid = 1'b1;
		cand[0].out_byte   = CH_BSL;
		cand[0].arg_index  = st.arg_total[3:0];
		cand[0].arg_count  = st.arg_total;

		cand[1]            = cand[0];
		cand[1].out_byte   = in_byte;

		cand[2]              = '0;
		cand[2].arg_index    = st.arg_total[3:0];
		cand[2].arg_end      = 1'b1;
		cand[2].arg_accepted = ok;
		cand[2].arg_count    = total_end;

		cand[3]             = '0;
		cand[3].arg_index   = tot_a[3:0];
		cand[3].string_done = 1'b1;
		cand[3].success     = ~fail_a;
		cand[3].arg_count   = tot_a;

		cv = {dn, en, emit_c, emit_bs};

		res = '0;
		k   = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && (k != 2'd3)) begin
				res[k] = cand[i];
				k      = k + 2'd1;
			end
		end
		if (k != 2'd0) begin
			res[k - 2'd1].last = 1'b1;
		end
		res_n = k;
	end

endmodule

`default_nettype wire

/* sv/qat_res_fifo.sv */
`default_nettype none

module qat_res_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         push_n,
	input  qat_pkg::res_t [qat_pkg::MAX_RES-1:0] push_data,
	input  logic                               pop,
	output qat_pkg::res_t                      head,
	output qat_pkg::fifo_stat_t                stat
);
	import qat_pkg::*;

	res_t             ent_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [PTR_W-1:0] off [FIFO_DEPTH];

	// slot offset of each entry from the write pointer
	always_comb begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			off[i] = PTR_W'(i) - wr_ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (2'(off[i]) < push_n) begin
				ent_q[i] <= push_data[off[i]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			level_q  <= level_q + LVL_W'(push_n) - LVL_W'(pop);
		end
	end

	assign head          = ent_q[rd_ptr_q];
	assign stat.room     = (level_q <= LVL_W'(FIFO_DEPTH - MAX_RES));
	assign stat.nonempty = (level_q != '0);
	assign stat.level    = level_q;

endmodule

`default_nettype wire

/* sv/quoted_argument_tokenizer.sv */
// Quoted argument tokenizer.
// Input channel: one character per transfer (in_valid / in_stall, in_byte).
// A zero byte closes the string; the next byte starts a fresh one.
// Output channel: one result per transfer (out_valid / out_stall): a character
// with its argument index, an argument end with its accept flag, or a string
// end with the success flag. last marks the final result of one input byte.
// A byte yields zero to three results.
// Results of a byte are written into the result queue when it is transferred.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver takes one per cycle; bytes giving two or three results hold
// the input back while the queue drains. A four-entry result queue sets this:
// a byte is taken whenever at most one result is queued.
// When the receiver stalls, the queue fills and in_stall rises; nothing is lost.
// Reset clears the queue, the scanner state, and sets max_args to 16 and
// store_limit to 1024. Configuration writes (cfg_we) take effect next cycle.
`default_nettype none

`include "quoted_argument_tokenizer_macros.svh"

module quoted_argument_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        char_valid,
	output logic [7:0]  out_byte,
	output logic [3:0]  arg_index,
	output logic        arg_end,
	output logic        arg_accepted,
	output logic        string_done,
	output logic        success,
	output logic [4:0]  arg_count,
	output logic        last
);
	import qat_pkg::*;

	logic [4:0]                 max_args_q;
	logic [12:0]                store_limit_q;
	tok_state_t                 state_q, state_next;
	res_t [MAX_RES-1:0]         step_res;
	logic [1:0]                 step_n, push_n;
	logic                       in_xfer, pop;
	res_t                       head;
	fifo_stat_t                 fstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q    <= MAX_ARGS_RST;
			store_limit_q <= STORE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ARGS:    max_args_q    <= cfg_wdata[4:0];
				REG_STORE_LIMIT: store_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qat_step u_step (
		.st          (state_q),
		.max_args    (max_args_q),
		.store_limit (store_limit_q),
		.in_byte     (in_byte),
		.st_next     (state_next),
		.res         (step_res),
		.res_n       (step_n)
	);

	assign in_stall = ~fstat.room;
	assign in_xfer  = in_valid & ~in_stall;
	assign push_n   = in_xfer ? step_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_xfer) begin
			state_q <= state_next;
		end
	end

	qat_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (step_res),
		.pop       (pop),
		.head      (head),
		.stat      (fstat)
	);

	assign out_valid    = fstat.nonempty;
	assign pop          = out_valid & ~out_stall;
	assign char_valid   = head.char_valid;
	assign out_byte     = head.out_byte;
	assign arg_index    = head.arg_index;
	assign arg_end      = head.arg_end;
	assign arg_accepted = head.arg_accepted;
	assign string_done  = head.string_done;
	assign success      = head.success;
	assign arg_count    = head.arg_count;
	assign last         = head.last;

	`QAT_ASSERT_IMPL(a_level_bound, clk, arst_n, 1'b1, fstat.level <= LVL_W'(FIFO_DEPTH))
	`QAT_ASSERT_NEXT(a_level_hold, clk, arst_n, (push_n == 2'd0) && !pop, $stable(fstat.level))
	`QAT_ASSERT_IMPL(a_done_last, clk, arst_n, out_valid && string_done, last)
	`QAT_ASSERT_IMPL(a_accept_count, clk, arst_n, out_valid && arg_end && arg_accepted, arg_count != 5'd0)

endmodule

`default_nettype wire
